/* rtl/vlcc_pkg.sv */
// Voxel line collision check: shared package.
// Holds the transaction payload types, function codes and the command and status
// structs that join the controller and the datapath. No dependencies.
`default_nettype none

package vlcc_pkg;

  localparam int COORD_W = 8;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic                      func;
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] az;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by;
    logic signed [COORD_W-1:0] bz;
    logic                      occupied;
  } vlcc_req_t;

  typedef struct packed {
    logic collision;
  } vlcc_rsp_t;

  typedef struct packed {
    logic capture;
    logic decode;
    logic init;
    logic step;
    logic wr_rd;
    logic wr_wr;
    logic clear;
    logic load_out;
  } vlcc_cmd_t;

  typedef struct packed {
    logic is_query;
    logic wr_ok;
    logic walk_done;
    logic clear_done;
    logic out_free;
  } vlcc_stat_t;

endpackage

`default_nettype wire

/* rtl/vlcc_if.sv */
// Voxel line collision check: request and response channel interfaces.
// Valid/ready handshake with payload; depends on vlcc_pkg.
`default_nettype none

interface vlcc_req_if;
  logic                valid;
  logic                ready;
  vlcc_pkg::vlcc_req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface vlcc_rsp_if;
  logic                valid;
  logic                ready;
  vlcc_pkg::vlcc_rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/vlcc_ctrl.sv */
// Voxel line collision check: controller state machine.
// Sequences map clearing, voxel writes and line walks; depends on vlcc_pkg.
`default_nettype none

module vlcc_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              req_valid_i,
  output logic                   req_ready_o,
  input  wire vlcc_pkg::vlcc_stat_t stat_i,
  output vlcc_pkg::vlcc_cmd_t    cmd_o
);
  import vlcc_pkg::*;

  typedef enum logic [7:0] {
    ST_CLEAR  = 8'b0000_0001,
    ST_IDLE   = 8'b0000_0010,
    ST_DECODE = 8'b0000_0100,
    ST_WR_RD  = 8'b0000_1000,
    ST_WR_WR  = 8'b0001_0000,
    ST_INIT   = 8'b0010_0000,
    ST_WALK   = 8'b0100_0000,
    ST_FINISH = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (stat_i.clear_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        req_ready_o   = 1'b1;
        cmd_o.capture = req_valid_i;
        if (req_valid_i) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        cmd_o.decode = 1'b1;
        priority if (stat_i.is_query) state_d = ST_INIT;
        else if (stat_i.wr_ok)        state_d = ST_WR_RD;
        else                          state_d = ST_IDLE;
      end
      ST_WR_RD: begin
        cmd_o.wr_rd = 1'b1;
        state_d     = ST_WR_WR;
      end
      ST_WR_WR: begin
        cmd_o.wr_wr = 1'b1;
        state_d     = ST_IDLE;
      end
      ST_INIT: begin
        cmd_o.init = 1'b1;
        state_d    = ST_WALK;
      end
      ST_WALK: begin
        if (stat_i.walk_done) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      ST_FINISH: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/vlcc_dp.sv */
// Voxel line collision check: datapath with occupancy map memory.
// Clamping, line stepping, row read-modify-write and result register;
// depends on vlcc_pkg.
`default_nettype none

module vlcc_dp #(
  parameter int SIDE = 64
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire vlcc_pkg::vlcc_req_t  req_i,
  input  wire vlcc_pkg::vlcc_cmd_t  cmd_i,
  output vlcc_pkg::vlcc_stat_t      stat_o,
  output logic                      rsp_valid_o,
  input  wire logic                 rsp_ready_i,
  output vlcc_pkg::vlcc_rsp_t       rsp_data_o
);
  import vlcc_pkg::*;

  localparam int CW   = $clog2(SIDE);
  localparam int ROWS = SIDE * SIDE;
  localparam int AW   = $clog2(ROWS);
  localparam int EW   = CW + 2;

  function automatic logic [CW-1:0] clamp(input logic signed [COORD_W-1:0] v);
    logic [COORD_W:0] vz;
    vz = {1'b0, v};
    priority if (v < 0)                 return '0;
    else if (int'(v) > SIDE - 1)        return CW'(SIDE - 1);
    else                                return CW'(vz);
  endfunction

  function automatic logic in_cube(input logic signed [COORD_W-1:0] v);
    return (v >= 0) && (int'(v) <= SIDE - 1);
  endfunction

  logic [CW-1:0] x_q, y_q, z_q, tx_q, ty_q, tz_q;
  logic [CW-1:0] x_d, y_d, z_d;
  logic          is_query_q, wr_ok_q, occ_q;
  logic [CW-1:0] dx_q, dy_q, dz_q, dm_q, cnt_q, zsel_q;
  logic          nx_q, ny_q, nz_q;
  logic [EW-1:0] ex_q, ey_q, ez_q, ex_d, ey_d, ez_d;
  logic [EW-1:0] ex_s, ey_s, ez_s;
  logic [CW-1:0] dm_c;
  logic          hit_q, hit_now, chk_q, out_valid_q, col_q;
  logic [AW-1:0] clr_q, row_addr, waddr;
  logic [SIDE-1:0] rdata_q, row_mod, wdata;
  logic          we, re;
  logic [SIDE-1:0] mem [ROWS];

  // Longest axis delta
  always_comb begin
    dm_c = dx_q;
    if (dy_q > dm_c) dm_c = dy_q;
    if (dz_q > dm_c) dm_c = dz_q;
  end

  // One Bresenham step on all three axes
  always_comb begin
    ex_s = ex_q - EW'(dx_q);
    ey_s = ey_q - EW'(dy_q);
    ez_s = ez_q - EW'(dz_q);
    ex_d = ex_s;
    ey_d = ey_s;
    ez_d = ez_s;
    x_d  = x_q;
    y_d  = y_q;
    z_d  = z_q;
    if (ex_s[EW-1]) begin
      ex_d = ex_s + EW'(dm_q);
      x_d  = nx_q ? x_q - CW'(1) : x_q + CW'(1);
    end
    if (ey_s[EW-1]) begin
      ey_d = ey_s + EW'(dm_q);
      y_d  = ny_q ? y_q - CW'(1) : y_q + CW'(1);
    end
    if (ez_s[EW-1]) begin
      ez_d = ez_s + EW'(dm_q);
      z_d  = nz_q ? z_q - CW'(1) : z_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      x_q        <= clamp(req_i.ax);
      y_q        <= clamp(req_i.ay);
      z_q        <= clamp(req_i.az);
      tx_q       <= clamp(req_i.bx);
      ty_q       <= clamp(req_i.by);
      tz_q       <= clamp(req_i.bz);
      is_query_q <= (req_i.func == FUNC_QUERY);
      wr_ok_q    <= in_cube(req_i.ax) && in_cube(req_i.ay) && in_cube(req_i.az);
      occ_q      <= req_i.occupied;
    end else if (cmd_i.step) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
    if (cmd_i.decode) begin
      dx_q <= (x_q > tx_q) ? x_q - tx_q : tx_q - x_q;
      dy_q <= (y_q > ty_q) ? y_q - ty_q : ty_q - y_q;
      dz_q <= (z_q > tz_q) ? z_q - tz_q : tz_q - z_q;
      nx_q <= !(x_q < tx_q);
      ny_q <= !(y_q < ty_q);
      nz_q <= !(z_q < tz_q);
    end
    if (cmd_i.init) begin
      dm_q  <= dm_c;
      ex_q  <= EW'(dm_c >> 1);
      ey_q  <= EW'(dm_c >> 1);
      ez_q  <= EW'(dm_c >> 1);
      cnt_q <= '0;
      hit_q <= 1'b0;
    end else begin
      hit_q <= hit_now;
      if (cmd_i.step) begin
        ex_q   <= ex_d;
        ey_q   <= ey_d;
        ez_q   <= ez_d;
        cnt_q  <= cnt_q + CW'(1);
      end
    end
    if (cmd_i.step) zsel_q <= z_q;
    if (cmd_i.load_out) col_q <= hit_now;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chk_q       <= 1'b0;
      out_valid_q <= 1'b0;
      clr_q       <= '0;
    end else begin
      chk_q <= cmd_i.step;
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.clear) clr_q <= clr_q + AW'(1);
    end
  end

  assign hit_now  = hit_q | (chk_q & rdata_q[zsel_q]);
  assign row_addr = AW'(x_q) * AW'(SIDE) + AW'(y_q);

  always_comb begin
    row_mod       = rdata_q;
    row_mod[z_q]  = occ_q;
  end

  assign re    = cmd_i.step | cmd_i.wr_rd;
  assign we    = cmd_i.wr_wr | cmd_i.clear;
  assign waddr = cmd_i.clear ? clr_q : row_addr;
  assign wdata = cmd_i.clear ? '0 : row_mod;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_q <= mem[row_addr];
  end

  assign stat_o.is_query   = is_query_q;
  assign stat_o.wr_ok      = wr_ok_q;
  assign stat_o.walk_done  = (cnt_q == dm_q);
  assign stat_o.clear_done = (clr_q == AW'(ROWS - 1));
  assign stat_o.out_free   = !out_valid_q | rsp_ready_i;

  assign rsp_valid_o          = out_valid_q;
  assign rsp_data_o.collision = col_q;

endmodule

`default_nettype wire

/* rtl/voxel_line_collision_check.sv */
// Voxel line collision check: top level joining controller and datapath.
// Depends on vlcc_pkg, vlcc_if, vlcc_ctrl and vlcc_dp.
//
// Keeps a SIDE^3 one-bit occupancy map, stored as SIDE^2 rows of SIDE bits in a memory with
// one read port and one write port. After reset the map is cleared one row per cycle; no
// request is taken during the clearing pass. A write request goes through decode, row read
// and row write back; a write with a coordinate outside the cube ends after decode and gives
// no response. A query walks dm steps, dm being the longest clamped axis delta (at most
// SIDE - 1), and reads one map row per cycle through the memory's read port. Each query
// gives one response; a finished response waits in an output register while the next
// request is taken.
`default_nettype none

module voxel_line_collision_check #(
  parameter int SIDE = 64
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  vlcc_req_if.sink   req_i,
  vlcc_rsp_if.source rsp_o
);
  import vlcc_pkg::*;

  vlcc_cmd_t  cmd;
  vlcc_stat_t stat;
  logic       req_ready;
  logic       rsp_valid;
  vlcc_rsp_t  rsp_data;

  vlcc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  vlcc_dp #(
    .SIDE (SIDE)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i.data),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (rsp_o.ready),
    .rsp_data_o  (rsp_data)
  );

  assign req_i.ready = req_ready;
  assign rsp_o.valid = rsp_valid;
  assign rsp_o.data  = rsp_data;

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_ready |=> !req_ready)
    else $error("request taken while a transaction is in progress");

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.step |-> !stat.walk_done)
    else $error("line walk stepped past its voxel count");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> stat.out_free)
    else $error("response loaded over an unaccepted response");

  a_clear_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clear |-> !req_ready && !cmd.wr_wr && !cmd.step)
    else $error("map access during clearing pass");

endmodule

`default_nettype wire
